### hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int CAP_W         = 5;
    localparam int MODE_W        = 3;
    localparam int CAP_RESET     = 16;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

    typedef struct packed {
        logic ok;
        logic empty;
        logic full;
    } status_t;

endpackage

### hw/rtl/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cdq_pkg::MODE_W-1:0]  mode,
    input  logic [cdq_pkg::WORD_W-1:0]  value,
    input  logic                        capacity_we,
    input  logic [cdq_pkg::CAP_W-1:0]   capacity,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [cdq_pkg::WORD_W-1:0]  mem_wdata,
    output logic [AW-1:0]               mem_raddr_front,
    output logic [AW-1:0]               mem_raddr_rear,
    output logic                        done,
    output cdq_pkg::status_t            status
);

    localparam int CAP_W = cdq_pkg::CAP_W;
    localparam int CW    = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam logic [CAP_W-1:0] CAP_INIT =
        CAP_W'((cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_REPLY = 2'd2;

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx,
                                              input logic [CAP_W-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(idx) + CW'(1);
        if (nxt >= CW'(cap))
        begin
            step_up = '0;
        end
        else
        begin
            step_up = nxt[AW-1:0];
        end
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx,
                                                input logic [CAP_W-1:0] cap);
        logic [CW-1:0] last;
        last = CW'(cap) - CW'(1);
        if (idx == '0)
        begin
            step_down = last[AW-1:0];
        end
        else
        begin
            step_down = idx - AW'(1);
        end
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CAP_W-1:0] occ_reg, occ_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    cdq_pkg::status_t status_reg, status_next;
    logic             accept;
    logic             is_full_now;
    logic             is_empty_now;
    logic [AW-1:0]    head_down;
    logic [CAP_W-1:0] cap_limited;

    assign accept       = start && !busy;
    assign busy         = (state_reg != ST_IDLE) || capacity_we;
    assign done         = (state_reg == ST_REPLY);
    assign status       = status_reg;
    assign is_full_now  = (occ_reg >= cap_reg);
    assign is_empty_now = (occ_reg == '0);
    assign head_down    = step_down(head_reg, cap_reg);

    assign mem_raddr_front = head_reg;
    assign mem_raddr_rear  = step_down(tail_reg, cap_reg);
    assign mem_wdata       = value;

    always_comb
    begin
        if (capacity == '0)
        begin
            cap_limited = CAP_W'(1);
        end
        else if (int'(capacity) > DEPTH)
        begin
            cap_limited = CAP_W'(DEPTH);
        end
        else
        begin
            cap_limited = capacity;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        cap_next    = cap_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (capacity_we)
                begin
                    cap_next  = cap_limited;
                    head_next = '0;
                    tail_next = '0;
                    occ_next  = '0;
                end
                else if (accept)
                begin
                    status_next.ok = 1'b0;
                    case (mode)
                        cdq_pkg::MODE_PUSH_FRONT:
                        begin
                            if (!is_full_now)
                            begin
                                head_next      = head_down;
                                mem_we         = 1'b1;
                                mem_waddr      = head_down;
                                occ_next       = occ_reg + CAP_W'(1);
                                status_next.ok = 1'b1;
                            end
                        end
                        cdq_pkg::MODE_PUSH_BACK:
                        begin
                            if (!is_full_now)
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = tail_reg;
                                tail_next      = step_up(tail_reg, cap_reg);
                                occ_next       = occ_reg + CAP_W'(1);
                                status_next.ok = 1'b1;
                            end
                        end
                        cdq_pkg::MODE_POP_FRONT:
                        begin
                            if (!is_empty_now)
                            begin
                                head_next      = step_up(head_reg, cap_reg);
                                occ_next       = occ_reg - CAP_W'(1);
                                status_next.ok = 1'b1;
                            end
                        end
                        cdq_pkg::MODE_POP_BACK:
                        begin
                            if (!is_empty_now)
                            begin
                                tail_next      = step_down(tail_reg, cap_reg);
                                occ_next       = occ_reg - CAP_W'(1);
                                status_next.ok = 1'b1;
                            end
                        end
                        cdq_pkg::MODE_QUERY:
                        begin
                            status_next.ok = 1'b1;
                        end
                        default:
                        begin
                            status_next.ok = 1'b0;
                        end
                    endcase
                    status_next.empty = (occ_next == '0);
                    status_next.full  = (occ_next >= cap_reg);
                    state_next        = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_INIT;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_reg)
        else $error("Occupancy exceeds the capacity in use.");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(head_reg) < CW'(cap_reg) && CW'(tail_reg) < CW'(cap_reg))
        else $error("A ring pointer lies outside the capacity in use.");

    a_read_then_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_REPLY))
        else $error("Read cycle was not followed by a reply.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !capacity_we |=> busy && !done)
        else $error("Accepted word did not make the block busy.");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status_reg.empty == (occ_reg == '0)))
        else $error("Reported empty flag disagrees with the occupancy.");

endmodule

### hw/rtl/circular_deque_core.sv
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit words held in a ring memory.
// A command word (mode, value) is taken at a rising edge where start is high
// and busy is low. Modes are push front, push back, pop front, pop back and
// query; other codes do nothing and report ok low.
// Each command produces one result word, presented in the reply state after
// the read state: done is high for exactly one cycle with ok, front_value,
// rear_value, is_empty and is_full. The receiver cannot stall; the result
// must be taken then. busy stays high from the cycle after acceptance through
// the result cycle, so no new command is taken before the last one's result.
// The registered ring memory sets the steps: update pointers and write, read
// front and rear, then present the registered read data.
// The capacity register is written with capacity_we while no command is in
// flight. busy is also high in any cycle where capacity_we is high, so a
// command is never taken together with a write. A write empties the deque;
// zero is treated as one and values above DEPTH are limited to DEPTH.
// Reset empties the deque and sets the capacity to 16, or DEPTH if smaller.
// The ring memory itself is not cleared; only written entries are ever read.

module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cdq_pkg::MODE_W-1:0]         mode,
    input  logic signed [cdq_pkg::WORD_W-1:0]  value,
    input  logic                               capacity_we,
    input  logic [cdq_pkg::CAP_W-1:0]          capacity,
    output logic                               done,
    output logic                               ok,
    output logic signed [cdq_pkg::WORD_W-1:0]  front_value,
    output logic signed [cdq_pkg::WORD_W-1:0]  rear_value,
    output logic                               is_empty,
    output logic                               is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [cdq_pkg::WORD_W-1:0]  mem_wdata;
    logic [AW-1:0]               mem_raddr_front;
    logic [AW-1:0]               mem_raddr_rear;
    logic [cdq_pkg::WORD_W-1:0]  mem_rdata_front;
    logic [cdq_pkg::WORD_W-1:0]  mem_rdata_rear;
    cdq_pkg::status_t            status;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .value           (value),
        .capacity_we     (capacity_we),
        .capacity        (capacity),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr_front (mem_raddr_front),
        .mem_raddr_rear  (mem_raddr_rear),
        .done            (done),
        .status          (status)
    );

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_front),
        .rdata_a (mem_rdata_front),
        .raddr_b (mem_raddr_rear),
        .rdata_b (mem_rdata_rear)
    );

    assign ok          = status.ok;
    assign is_empty    = status.empty;
    assign is_full     = status.full;
    assign front_value = status.empty ? $signed(cdq_pkg::EMPTY_WORD)
                                      : $signed(mem_rdata_front);
    assign rear_value  = status.empty ? $signed(cdq_pkg::EMPTY_WORD)
                                      : $signed(mem_rdata_rear);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cdq_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEFAULT;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 240;

    typedef struct {
        status_t           flags;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] rear;
    } deque_view_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic [MODE_W-1:0]        mode        = MODE_QUERY;
    logic signed [WORD_W-1:0] value       = '0;
    logic                     capacity_we = 1'b0;
    logic [CAP_W-1:0]         capacity    = CAP_W'(CAP_RESET);
    wire                      busy;
    wire                      done;
    wire                      ok;
    wire signed [WORD_W-1:0]  front_value;
    wire signed [WORD_W-1:0]  rear_value;
    wire                      is_empty;
    wire                      is_full;

    logic [WORD_W-1:0] ring_copy [RING_DEPTH];
    logic [PTR_W-1:0]  head_ptr;
    logic [PTR_W-1:0]  tail_ptr;
    logic [CAP_W-1:0]  fill_count;
    logic [CAP_W-1:0]  cap_in_use;
    deque_view_t       view_q [$];
    int                fail_count   = 0;
    int                stall_cycles = 0;
    int                idle_pct     = 0;

    circular_deque_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .value      (value),
        .capacity_we(capacity_we),
        .capacity   (capacity),
        .done       (done),
        .ok         (ok),
        .front_value(front_value),
        .rear_value (rear_value),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    always #1 clk = ~clk;

    function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] raw);
        if (raw == '0)
            return CAP_W'(1);
        if (int'(raw) > RING_DEPTH)
            return CAP_W'(RING_DEPTH);
        return raw;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_up(input logic [PTR_W-1:0] p);
        if (int'(p) + 1 >= int'(cap_in_use))
            return '0;
        return p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
        if (p == '0)
            return PTR_W'(cap_in_use - 1'b1);
        return p - 1'b1;
    endfunction

    function automatic deque_view_t apply_word(input logic [MODE_W-1:0] m,
                                               input logic [WORD_W-1:0] v);
        deque_view_t r;
        logic        was_full;
        logic        was_empty;
        was_full  = fill_count >= cap_in_use;
        was_empty = fill_count == '0;
        r.flags.ok = 1'b0;
        case (m)
            MODE_PUSH_FRONT:
            begin
                if (!was_full)
                begin
                    head_ptr = ptr_down(head_ptr);
                    ring_copy[head_ptr] = v;
                    fill_count = fill_count + 1'b1;
                    r.flags.ok = 1'b1;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (!was_full)
                begin
                    ring_copy[tail_ptr] = v;
                    tail_ptr = ptr_up(tail_ptr);
                    fill_count = fill_count + 1'b1;
                    r.flags.ok = 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (!was_empty)
                begin
                    head_ptr = ptr_up(head_ptr);
                    fill_count = fill_count - 1'b1;
                    r.flags.ok = 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                if (!was_empty)
                begin
                    tail_ptr = ptr_down(tail_ptr);
                    fill_count = fill_count - 1'b1;
                    r.flags.ok = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                r.flags.ok = 1'b1;
            end
            default:
            begin
                r.flags.ok = 1'b0;
            end
        endcase
        r.flags.empty = fill_count == '0;
        r.flags.full  = fill_count >= cap_in_use;
        r.front = r.flags.empty ? EMPTY_WORD : ring_copy[head_ptr];
        r.rear  = r.flags.empty ? EMPTY_WORD : ring_copy[ptr_down(tail_ptr)];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2: return EMPTY_WORD;
            3: return '0;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] v);
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        view_q.push_back(apply_word(m, v));
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] raw);
        start <= 1'b0;
        wait (view_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        while (busy !== 1'b0)
            @(negedge clk);
        capacity_we <= 1'b1;
        capacity    <= raw;
        cap_in_use = clamp_capacity(raw);
        head_ptr   = '0;
        tail_ptr   = '0;
        fill_count = '0;
        @(negedge clk);
        capacity_we <= 1'b0;
    endtask

    task automatic test_empty_and_extremes();
        send_word(MODE_QUERY, pick_value());
        send_word(MODE_POP_FRONT, pick_value());
        send_word(MODE_POP_BACK, pick_value());
        send_word(MODE_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});
        send_word(MODE_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}});
        send_word(MODE_PUSH_FRONT, EMPTY_WORD);
        send_word(MODE_PUSH_BACK, '0);
        send_word(MODE_POP_FRONT, pick_value());
        send_word(MODE_POP_BACK, pick_value());
    endtask

    task automatic test_unused_modes();
        send_word(MODE_QUERY + 3'd1, pick_value());
        send_word(MODE_QUERY + 3'd2, pick_value());
        send_word(MODE_QUERY + 3'd3, pick_value());
    endtask

    task automatic test_capacity_zero();
        set_capacity('0);
        send_word(MODE_PUSH_BACK, pick_value());
        send_word(MODE_PUSH_FRONT, pick_value());
        send_word(MODE_POP_FRONT, pick_value());
        send_word(MODE_POP_BACK, pick_value());
    endtask

    task automatic test_capacity_over_depth();
        set_capacity('1);
        send_word(MODE_PUSH_FRONT, pick_value());
        send_word(MODE_PUSH_BACK, pick_value());
    endtask

    task automatic test_random_traffic(input int pct, input logic [CAP_W-1:0] raw,
                                       input int n_words);
        bit                filling;
        int                run_left;
        int                r;
        logic [MODE_W-1:0] m;
        set_capacity(raw);
        idle_pct = pct;
        filling  = 1'b0;
        run_left = 0;
        repeat (n_words)
        begin
            if (run_left == 0)
            begin
                filling  = !filling;
                run_left = $urandom_range(2 * int'(cap_in_use) + 4, 1);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 3)
                m = MODE_QUERY + MODE_W'($urandom_range(3, 1));
            else if (r < 8)
                m = MODE_QUERY;
            else if ((r < 80) == filling)
                m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else
                m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_word(m, pick_value());
        end
        idle_pct = 0;
    endtask

    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (view_q.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: result with none expected, actual ok %b front %h rear %h",
                         $time, ok, front_value, rear_value);
            end
            else
            begin
                want = view_q.pop_front();
                check_field("ok", WORD_W'(want.flags.ok), WORD_W'(ok));
                check_field("front_value", want.front, front_value);
                check_field("rear_value", want.rear, rear_value);
                check_field("is_empty", WORD_W'(want.flags.empty), WORD_W'(is_empty));
                check_field("is_full", WORD_W'(want.flags.full), WORD_W'(is_full));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("circular_deque_core verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            ring_copy[i] = '0;
        head_ptr   = '0;
        tail_ptr   = '0;
        fill_count = '0;
        cap_in_use = clamp_capacity(CAP_W'(CAP_RESET));
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_empty_and_extremes();
        test_unused_modes();
        test_capacity_zero();
        test_capacity_over_depth();

        test_random_traffic(0, CAP_W'(RING_DEPTH), RANDOM_WORDS);
        test_random_traffic(0, CAP_W'(1), RANDOM_WORDS);
        test_random_traffic(54, '0, RANDOM_WORDS);
        test_random_traffic(54, '1, RANDOM_WORDS);
        test_random_traffic(0, CAP_W'($urandom_range(15, 2)), RANDOM_WORDS);
        test_random_traffic(0, CAP_W'($urandom_range(15, 2)), RANDOM_WORDS);
        test_random_traffic(9, CAP_W'(RING_DEPTH), RANDOM_WORDS);
        test_random_traffic(9, CAP_W'($urandom_range(15, 2)), RANDOM_WORDS);

        start <= 1'b0;
        wait (view_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && view_q.size() == 0)
            $display("circular_deque_core verification clean");
        else
            $display("circular_deque_core verification failed");
        $finish;
    end

endmodule
